/* rtl/kat_pkg.sv */
// kat_pkg: shared constants, codes and types of the keyed accumulate table
// no dependencies; compiled first
package kat_pkg;

  // default sizes, used as the defaults of the top level parameters
  localparam int ENTRIES_DEF    = 64;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // fixed widths of the channel words
  localparam int REQ_TYPE_W = 2;
  localparam int KEY_W      = 64;
  localparam int AMOUNT_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int STORED_W   = 32;

  // request kinds
  localparam logic [REQ_TYPE_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_ERASE = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_QUERY = 2'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_NONE  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ACT
  } kat_state_t;

  // compare flags of one stored entry against the request key
  typedef struct packed {
    logic hit;
    logic free;
  } kat_cmp_t;

endpackage

/* rtl/kat_if.sv */
// kat_req_if, kat_rsp_if: valid/ready channels of the keyed accumulate table
// depends on kat_pkg for the word widths
interface kat_req_if;
  logic                          valid;
  logic                          ready;
  logic [kat_pkg::REQ_TYPE_W-1:0] req_type;
  logic [kat_pkg::KEY_W-1:0]      key;
  logic [kat_pkg::AMOUNT_W-1:0]   amount;

  modport source (output valid, output req_type, output key, output amount, input ready);
  modport sink   (input valid, input req_type, input key, input amount, output ready);
endinterface

interface kat_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [kat_pkg::STATUS_W-1:0] status;
  logic [kat_pkg::STORED_W-1:0] stored_value;

  modport source (output valid, output status, output stored_value, input ready);
  modport sink   (input valid, input status, input stored_value, output ready);
endinterface

/* rtl/kat_ram.sv */
// kat_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module kat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/kat_unit.sv */
// kat_unit: shared key compare and saturating add unit
// depends on kat_pkg for the compare flag struct
module kat_unit #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                  entry_valid,
  input  logic [KEY_BITS-1:0]   entry_key,
  input  logic [KEY_BITS-1:0]   req_key,
  input  logic [VALUE_BITS-1:0] acc_a,
  input  logic [VALUE_BITS-1:0] acc_b,
  output kat_pkg::kat_cmp_t     cmp,
  output logic [VALUE_BITS-1:0] sum
);
  import kat_pkg::*;

  logic [VALUE_BITS:0] wide_sum;

  // key match against one stored entry
  always_comb begin
    cmp.hit  = entry_valid && (entry_key == req_key);
    cmp.free = !entry_valid;
  end

  // saturating add, clamps at the all-ones value
  assign wide_sum = {1'b0, acc_a} + {1'b0, acc_b};
  assign sum      = wide_sum[VALUE_BITS] ? '1 : wide_sum[VALUE_BITS-1:0];

endmodule

/* rtl/keyed_accumulate_table.sv */
// keyed_accumulate_table: top level, sequencer and output register
// depends on kat_pkg, kat_if, kat_ram and kat_unit
//
// Associative table of ENTRIES key/value pairs held in one ram word per slot
// ({valid, key, value}). A request is taken only while the sequencer is idle;
// it then scans the ram one slot per cycle through the shared compare unit,
// stopping at the first key match. An add, query or erase passes through
// accept, a scan of every slot through the registered read (cut short on a
// match) and an update step; request kind 3 is dropped in the accept cycle.
// The scan length is set by the single ram read port. After reset a clearing
// pass writes every slot invalid before the first request is taken. The
// result word sits in an output register, so a new request is taken while it
// waits; an add or query update holds only when a second result would
// overrun it, and an erase, which gives no result, never holds.
module keyed_accumulate_table #(
  parameter int ENTRIES    = kat_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = kat_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = kat_pkg::VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  kat_req_if.sink   req,
  kat_rsp_if.source rsp
);
  import kat_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = 1 + KEY_BITS + VALUE_BITS;

  kat_state_t state, state_next;

  logic [CNT_W-1:0]      iss, iss_next;
  logic                  chk_vld, chk_vld_next;
  logic [IDX_W-1:0]      chk_idx, chk_idx_next;
  logic [REQ_TYPE_W-1:0] req_q, req_q_next;
  logic [KEY_BITS-1:0]   key_q, key_q_next;
  logic [VALUE_BITS-1:0] amt_q, amt_q_next;
  logic                  hit, hit_next;
  logic [IDX_W-1:0]      hit_idx, hit_idx_next;
  logic [VALUE_BITS-1:0] hit_val, hit_val_next;
  logic                  free_found, free_found_next;
  logic [IDX_W-1:0]      free_idx, free_idx_next;
  logic                  out_valid, out_valid_next;
  logic [STATUS_W-1:0]   out_status, out_status_next;
  logic [VALUE_BITS-1:0] out_value, out_value_next;

  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [WORD_W-1:0]     wdata;
  logic [WORD_W-1:0]     rdata;
  logic                  rd_valid;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic [VALUE_BITS-1:0] amt_clamp;
  logic [VALUE_BITS-1:0] sum;
  kat_cmp_t              cmp;
  logic                  matched;
  logic                  space;

  // clamp the incoming amount to the value range
  if (VALUE_BITS >= AMOUNT_W) begin : g_amt_wide
    assign amt_clamp = VALUE_BITS'(req.amount);
  end else begin : g_amt_narrow
    assign amt_clamp = (|req.amount[AMOUNT_W-1:VALUE_BITS]) ? '1
                                                            : req.amount[VALUE_BITS-1:0];
  end

  // fit the held value to the result word
  if (VALUE_BITS >= STORED_W) begin : g_out_wide
    assign rsp.stored_value = out_value[STORED_W-1:0];
  end else begin : g_out_narrow
    assign rsp.stored_value = STORED_W'(out_value);
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign req.ready  = (state == S_IDLE);

  // slot storage
  kat_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (iss[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign rd_valid = rdata[WORD_W-1];
  assign rd_key   = rdata[VALUE_BITS +: KEY_BITS];
  assign rd_val   = rdata[VALUE_BITS-1:0];

  // shared compare and add unit
  kat_unit #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_unit (
    .entry_valid (rd_valid),
    .entry_key   (rd_key),
    .req_key     (key_q),
    .acc_a       (hit_val),
    .acc_b       (amt_q),
    .cmp         (cmp),
    .sum         (sum)
  );

  assign matched = chk_vld && cmp.hit;
  assign space   = !out_valid || rsp.ready;

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      iss        <= '0;
      chk_vld    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      iss        <= iss_next;
      chk_vld    <= chk_vld_next;
      hit        <= hit_next;
      free_found <= free_found_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chk_idx    <= chk_idx_next;
    req_q      <= req_q_next;
    key_q      <= key_q_next;
    amt_q      <= amt_q_next;
    hit_idx    <= hit_idx_next;
    hit_val    <= hit_val_next;
    free_idx   <= free_idx_next;
    out_status <= out_status_next;
    out_value  <= out_value_next;
  end

  // sequencer: clear, accept, scan, update
  always_comb begin
    state_next      = state;
    iss_next        = iss;
    chk_vld_next    = chk_vld;
    chk_idx_next    = chk_idx;
    req_q_next      = req_q;
    key_q_next      = key_q;
    amt_q_next      = amt_q;
    hit_next        = hit;
    hit_idx_next    = hit_idx;
    hit_val_next    = hit_val;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_value_next  = out_value;
    we              = 1'b0;
    waddr           = hit_idx;
    wdata           = '0;

    case (state)
      S_CLEAR: begin
        we       = 1'b1;
        waddr    = iss[IDX_W-1:0];
        wdata    = '0;
        iss_next = iss + 1'b1;
        if (iss == CNT_W'(ENTRIES - 1)) begin
          iss_next   = '0;
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req.valid && (req.req_type != REQ_NONE)) begin
          req_q_next      = req.req_type;
          key_q_next      = req.key[KEY_BITS-1:0];
          amt_q_next      = amt_clamp;
          iss_next        = '0;
          chk_vld_next    = 1'b0;
          hit_next        = 1'b0;
          free_found_next = 1'b0;
          state_next      = S_SCAN;
        end
      end

      S_SCAN: begin
        // check the word read last cycle
        if (chk_vld) begin
          if (cmp.hit) begin
            hit_next     = 1'b1;
            hit_idx_next = chk_idx;
            hit_val_next = rd_val;
          end else if (cmp.free && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = chk_idx;
          end
        end
        // issue the next read
        if (!matched && (iss < CNT_W'(ENTRIES))) begin
          chk_vld_next = 1'b1;
          chk_idx_next = iss[IDX_W-1:0];
          iss_next     = iss + 1'b1;
        end else begin
          chk_vld_next = 1'b0;
        end
        if (matched || (chk_vld && (chk_idx == IDX_W'(ENTRIES - 1)))) begin
          state_next = S_ACT;
        end
      end

      S_ACT: begin
        case (req_q)
          REQ_ADD: begin
            if (space) begin
              out_valid_next = 1'b1;
              state_next     = S_IDLE;
              if (hit) begin
                we              = 1'b1;
                waddr           = hit_idx;
                wdata           = {1'b1, key_q, sum};
                out_status_next = STS_FOUND;
                out_value_next  = sum;
              end else if (free_found) begin
                we              = 1'b1;
                waddr           = free_idx;
                wdata           = {1'b1, key_q, amt_q};
                out_status_next = STS_NOT_FOUND;
                out_value_next  = amt_q;
              end else begin
                out_status_next = STS_FULL;
                out_value_next  = '0;
              end
            end
          end
          REQ_ERASE: begin
            if (hit) begin
              we    = 1'b1;
              waddr = hit_idx;
              wdata = {1'b0, key_q, hit_val};
            end
            state_next = S_IDLE;
          end
          REQ_QUERY: begin
            if (space) begin
              out_valid_next  = 1'b1;
              out_status_next = hit ? STS_FOUND : STS_NOT_FOUND;
              out_value_next  = hit ? hit_val : '0;
              state_next      = S_IDLE;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* tb/kat_table_check_pkg.sv */
// kat_table_check_pkg: expected-reply tracking for the keyed accumulate table bench
// depends on kat_pkg for codes, widths and default sizes
package kat_table_check_pkg;
  import kat_pkg::*;

  localparam int SLOTS = ENTRIES_DEF;
  localparam logic [63:0] VALUE_TOP =
    (VALUE_BITS_DEF >= 64) ? '1 : (64'd1 << VALUE_BITS_DEF) - 64'd1;
  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS_DEF >= KEY_W) ? '1 : (64'd1 << KEY_BITS_DEF) - 64'd1;
  localparam int PRINT_CAP = 100;

  // one reply word as the block should send it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [STORED_W-1:0] value;
  } kat_reply_t;

  class kat_table_model;
    bit               slot_used [SLOTS];
    logic [KEY_W-1:0] slot_key  [SLOTS];
    logic [63:0]      slot_value[SLOTS];
    kat_reply_t       replies_due[$];
    int               errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      errors = 0;
    endfunction

    function int pending_count();
      return replies_due.size();
    endfunction

    // apply one accepted request word to the mirrored table
    function void note_request(logic [REQ_TYPE_W-1:0] kind, logic [KEY_W-1:0] key_in,
                               logic [AMOUNT_W-1:0] amount_in);
      logic [KEY_W-1:0] k;
      logic [63:0]      amt;
      logic [64:0]      sum;
      int               hit;
      int               hole;
      kat_reply_t       r;
      k    = key_in & KEY_MASK;
      amt  = (64'(amount_in) > VALUE_TOP) ? VALUE_TOP : 64'(amount_in);
      hit  = -1;
      hole = -1;
      // scan downward so the lowest matching and lowest free slots win
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_key[i] == k) hit = i;
        if (!slot_used[i]) hole = i;
      end
      case (kind)
        REQ_ADD: begin
          if (hit >= 0) begin
            sum = slot_value[hit] + amt;
            slot_value[hit] = (sum > VALUE_TOP) ? VALUE_TOP : sum[63:0];
            r.status = STS_FOUND;
            r.value  = slot_value[hit][STORED_W-1:0];
          end else if (hole >= 0) begin
            slot_used[hole]  = 1'b1;
            slot_key[hole]   = k;
            slot_value[hole] = amt;
            r.status = STS_NOT_FOUND;
            r.value  = amt[STORED_W-1:0];
          end else begin
            r.status = STS_FULL;
            r.value  = '0;
          end
          replies_due = {replies_due, r};
        end
        REQ_ERASE: begin
          if (hit >= 0) slot_used[hit] = 1'b0;
        end
        REQ_QUERY: begin
          if (hit >= 0) begin
            r.status = STS_FOUND;
            r.value  = slot_value[hit][STORED_W-1:0];
          end else begin
            r.status = STS_NOT_FOUND;
            r.value  = '0;
          end
          replies_due = {replies_due, r};
        end
        default: begin
          // unused request kind leaves the table alone
        end
      endcase
    endfunction

    // compare one accepted reply word with the oldest expectation
    function void check_reply(logic [STATUS_W-1:0] status_in, logic [STORED_W-1:0] value_in);
      kat_reply_t want;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: reply with none expected, actual status %0d value %0h",
                   $time, status_in, value_in);
        return;
      end
      want = replies_due.pop_front();
      if (status_in !== want.status) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_in);
      end
      if (value_in !== want.value) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: stored_value expected %0h actual %0h", $time, want.value, value_in);
      end
    endfunction
  endclass

endpackage

/* tb/keyed_accumulate_table_tb.sv */
// keyed_accumulate_table_tb: directed and random add/erase/query traffic with a
// mirrored table checking every reply; depends on kat_pkg, kat_if, kat_table_check_pkg
module keyed_accumulate_table_tb;
  import kat_pkg::*;
  import kat_table_check_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = ENTRIES_DEF + 40;
  localparam int ITEM_TARGET    = 1800;
  localparam int POOL_MAX       = 100;
  localparam int HOLDOFF_AT     = 400;
  localparam int HOLDOFF_CYCLES = 800;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  kat_req_if req ();
  kat_rsp_if rsp ();

  keyed_accumulate_table u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  kat_table_model   table_model = new();
  logic [KEY_W-1:0] key_pool[POOL_MAX];
  int               words_sent  = 0;
  bit               holdoff_done = 1'b0;
  int               idle_count  = 0;

  // offer one request word and wait for it to be taken
  task automatic send_word(input logic [REQ_TYPE_W-1:0] kind, input logic [KEY_W-1:0] k,
                           input logic [AMOUNT_W-1:0] amt);
    @(negedge clk);
    req.valid    <= 1'b1;
    req.req_type <= kind;
    req.key      <= k;
    req.amount   <= amt;
    do @(posedge clk); while (!req.ready);
    table_model.note_request(kind, k, amt);
    words_sent++;
  endtask

  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
  endtask

  task automatic wait_drain();
    pause_sender(1);
    while (table_model.pending_count() != 0) @(posedge clk);
  endtask

  // one random request word, its key drawn from the first pool_size keys of the pool or at random
  task automatic send_random(input int pool_size, input int add_w, input int erase_w,
                             input int query_w);
    int                    r;
    logic [REQ_TYPE_W-1:0] kind;
    logic [KEY_W-1:0]      k;
    logic [AMOUNT_W-1:0]   amt;
    r = $urandom_range(0, 99);
    if (r < add_w) kind = REQ_ADD;
    else if (r < add_w + erase_w) kind = REQ_ERASE;
    else if (r < add_w + erase_w + query_w) kind = REQ_QUERY;
    else kind = REQ_NONE;
    if ($urandom_range(0, 15) == 0) k = {$urandom, $urandom};
    else k = key_pool[$urandom_range(0, pool_size - 1)];
    case ($urandom_range(0, 9))
      0:       amt = '0;
      1:       amt = '1;
      2:       amt = 32'hFFFF_FFFF - $urandom_range(0, 255);
      3:       amt = $urandom_range(0, 15);
      4:       amt = 32'd1 << $urandom_range(0, AMOUNT_W - 1);
      default: amt = $urandom;
    endcase
    send_word(kind, k, amt);
  endtask

  // reply side: stall pattern of its own plus one long hold-off
  initial begin : rsp_side
    int mode;
    int left;
    rsp.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (!holdoff_done && words_sent >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 300);
      end
      left--;
      case (mode)
        0:       rsp.ready <= 1'b1;
        1:       rsp.ready <= $urandom_range(0, 1);
        2:       rsp.ready <= ($urandom_range(0, 7) == 0);
        default: rsp.ready <= (left % 5 != 0);
      endcase
    end
  end

  // reply check at the rising edge
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      table_model.check_reply(rsp.status, rsp.stored_value);
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int pool_size;
    int add_w;
    int erase_w;
    int query_w;
    int phase;
    req.valid    = 1'b0;
    req.req_type = REQ_ADD;
    req.key      = '0;
    req.amount   = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_MAX; i++) key_pool[i] = {$urandom, $urandom};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, insert, hit, saturation, erase, unused kind
    send_word(REQ_QUERY, 64'h0, 32'h0);
    send_word(REQ_ADD,   64'h0, 32'h0);
    send_word(REQ_ADD,   '1,    '1);
    send_word(REQ_ADD,   '1,    32'h1);
    send_word(REQ_ADD,   64'h0, 32'h5);
    send_word(REQ_QUERY, 64'h0, 32'h0);
    send_word(REQ_QUERY, '1,    32'h0);
    send_word(REQ_ERASE, 64'h0, '1);
    send_word(REQ_QUERY, 64'h0, 32'h0);
    send_word(REQ_ERASE, 64'h0, 32'h0);
    send_word(REQ_NONE,  '1,    '1);
    send_word(REQ_QUERY, '1,    '1);
    // sum landing exactly on the top, then carry out of the word
    send_word(REQ_ADD,   64'h8000_0000_0000_0000, 32'h7FFF_FFFF);
    send_word(REQ_ADD,   64'h8000_0000_0000_0000, 32'h8000_0000);
    send_word(REQ_ADD,   64'h8000_0000_0000_0000, 32'h0);
    send_word(REQ_ADD,   64'h8000_0000_0000_0000, '1);
    // keys one bit apart from stored or erased ones
    send_word(REQ_QUERY, 64'h0000_0000_0000_0001, 32'h0);
    send_word(REQ_ADD,   64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    send_word(REQ_ADD,   64'h5555_5555_5555_5555, 32'h5555_5555);
    send_word(REQ_QUERY, 64'hAAAA_AAAA_AAAA_AAAB, 32'h0);
    send_word(REQ_ERASE, '1,    32'h0);
    send_word(REQ_QUERY, '1,    32'h0);
    send_word(REQ_QUERY, 64'h5555_5555_5555_5555, 32'h0);

    // random phases: the first fills the table, later ones vary pool and mix
    phase = 0;
    while (words_sent < ITEM_TARGET) begin
      if (phase == 0) begin
        pool_size = POOL_MAX;
        add_w     = 85;
        erase_w   = 5;
        query_w   = 8;
      end else begin
        pool_size = ($urandom_range(0, 2) == 0) ? $urandom_range(70, POOL_MAX)
                                                : $urandom_range(3, 12);
        add_w     = $urandom_range(30, 70);
        erase_w   = $urandom_range(5, 25);
        query_w   = 96 - add_w - erase_w;
      end
      repeat ($urandom_range(8, 30)) begin
        repeat ($urandom_range(1, 16)) send_random(pool_size, add_w, erase_w, query_w);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 40));
      end
      if (phase % 3 == 1) wait_drain();
      phase++;
    end

    // drain, then allow for a trailing word that causes no reply
    pause_sender(1);
    while (table_model.pending_count() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (table_model.errors == 0 && table_model.pending_count() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
